@@ hw/rtl/kssv_pkg.sv @@
// Package for the keyed sawtooth voice: shared widths, key/volume limits,
// the phase step table and the knob direction codes. No dependencies.
`timescale 1ns / 1ps

package kssv_pkg;

   // Fixed field and state widths
   localparam int MatrixWidth = 16;
   localparam int SampleWidth = 8;
   localparam int VolumeWidth = 4;
   localparam int PhaseWidth  = 32;
   localparam int KeyIdxWidth = 4;

   // Matrix layout and limits
   localparam int KEY_COUNT   = 12;  // keys scanned, indices 0..11
   localparam int VOLUME_MAX  = 8;   // top of volume range, 0..8
   localparam int KnobHiBit   = 12;
   localparam int KnobLoBit   = 13;

   localparam logic [SampleWidth-1:0] SampleMid = 8'd128;

   // Knob direction, two's complement in two bits
   typedef enum logic [1:0] {
      DIR_NONE = 2'b00,
      DIR_UP   = 2'b01,
      DIR_BAD  = 2'b10,
      DIR_DOWN = 2'b11
   } dir_type;

   // Item kinds
   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Result item as held in the output stages
   typedef struct packed {
      logic [SampleWidth-1:0] audio_level;
      logic [VolumeWidth-1:0] volume_level;
      logic                   note_active;
   } rsp_type;

   // Phase step per key: floor(2^32 * 440 * 2^((n-9)/12) / 22000)
   function automatic logic [PhaseWidth-1:0] step_lookup(input logic [KeyIdxWidth-1:0] idx);
      logic [PhaseWidth-1:0] step;
      case (idx)
         4'd0:    step = 32'd51076056;
         4'd1:    step = 32'd54113197;
         4'd2:    step = 32'd57330935;
         4'd3:    step = 32'd60740009;
         4'd4:    step = 32'd64351798;
         4'd5:    step = 32'd68178356;
         4'd6:    step = 32'd72232452;
         4'd7:    step = 32'd76527617;
         4'd8:    step = 32'd81078186;
         4'd9:    step = 32'd85899345;
         4'd10:   step = 32'd91007186;
         4'd11:   step = 32'd96418755;
         default: step = '0;
      endcase
      return step;
   endfunction

endpackage

@@ hw/rtl/keyed_sawtooth_synth_voice_core.sv @@
// Top level of the keyed sawtooth voice: knob/key decode, phase accumulator
// and a two-deep result stage. Depends on kssv_pkg.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  req     | in        | req_valid / req_ready  | req_type, req_matrix_bits
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_audio_level, rsp_volume_level,
//          |           |                        | rsp_note_active
//
//  One item per cycle while req_ready is high; each result is registered in the result or skid register.
//  All state is updated in the accepting cycle by one add, a priority encode
//  and a shift, so the next item may follow straight away.
//  A result register plus a skid register hold up to two results; req_ready
//  drops only while the skid register is occupied.
//  Synchronous reset: phase, step, volume and knob history to zero, held
//  sample to mid scale, both result stages empty.

module keyed_sawtooth_synth_voice_core
   import kssv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [MatrixWidth-1:0] req_matrix_bits,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SampleWidth-1:0] rsp_audio_level,
   output logic [VolumeWidth-1:0] rsp_volume_level,
   output logic                   rsp_note_active
);

   // Voice state
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [PhaseWidth-1:0]  step_ff, step_in;
   logic [VolumeWidth-1:0] volume_ff, volume_in;
   logic [1:0]             knob_ff, knob_in;
   dir_type                last_dir_ff, last_dir_in;
   logic [SampleWidth-1:0] sample_ff, sample_in;

   // Result stages
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   logic    req_xfer;
   logic    rsp_xfer;
   rsp_type result;

   // Scan decode signals
   logic [1:0]             knob_cur;
   dir_type                dir;
   logic signed [5:0]      vol_sum;
   logic [KeyIdxWidth-1:0] key_idx;
   logic                   key_hit;
   logic [PhaseWidth-1:0]  phase_sum;
   logic signed [SampleWidth-1:0] centred;
   logic signed [SampleWidth-1:0] scaled;
   logic [3:0]             shift_amt;

   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = out_valid_ff && rsp_ready;

   // Quadrature decode: pair is {bit12, bit13}
   assign knob_cur = {req_matrix_bits[KnobHiBit], req_matrix_bits[KnobLoBit]};

   always_comb begin
      dir = DIR_NONE;
      case (knob_ff)
         2'b00: begin
            if (knob_cur == 2'b01) dir = DIR_UP;
            else if (knob_cur == 2'b11) dir = last_dir_ff;
         end
         2'b01: begin
            if (knob_cur == 2'b00) dir = DIR_DOWN;
            else if (knob_cur == 2'b10) dir = last_dir_ff;
         end
         2'b10: begin
            if (knob_cur == 2'b11) dir = DIR_DOWN;
            else if (knob_cur == 2'b01) dir = last_dir_ff;
         end
         default: begin
            if (knob_cur == 2'b10) dir = DIR_UP;
            else if (knob_cur == 2'b00) dir = last_dir_ff;
         end
      endcase
   end

   // Sign-extended direction; the stray code 2 reads as -2, as in two bits
   assign vol_sum = $signed({2'b00, volume_ff}) + $signed({{4{dir[1]}}, dir});

   // Lowest pressed key wins (active low)
   always_comb begin
      key_idx = '0;
      key_hit = 1'b0;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (!req_matrix_bits[i]) begin
            key_idx = KeyIdxWidth'(i);
            key_hit = 1'b1;
         end
      end
   end

   // Next voice state
   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      volume_in   = volume_ff;
      knob_in     = knob_ff;
      last_dir_in = last_dir_ff;
      sample_in   = sample_ff;
      if (req_xfer) begin
         if (req_type == REQ_SCAN) begin
            step_in = key_hit ? step_lookup(key_idx) : '0;
            if (vol_sum > $signed(6'(VOLUME_MAX))) begin
               volume_in = VolumeWidth'(VOLUME_MAX);
            end else if (vol_sum < 6'sd0) begin
               volume_in = '0;
            end else begin
               volume_in   = vol_sum[VolumeWidth-1:0];
               last_dir_in = dir;
               knob_in     = knob_cur;
            end
         end else begin
            phase_in  = phase_sum;
            sample_in = scaled ^ SampleMid;
         end
      end
   end

   // Sawtooth: top byte re-centred, scaled by volume, then offset back
   assign phase_sum = phase_ff + step_ff;
   assign centred   = $signed(phase_sum[PhaseWidth-1 -: SampleWidth] ^ SampleMid);
   assign shift_amt = (volume_ff <= 4'd8) ? (4'd8 - volume_ff) : 4'd0;
   assign scaled    = centred >>> shift_amt;

   always_comb begin
      result.audio_level  = sample_in;
      result.volume_level = volume_in;
      result.note_active  = (step_in != '0);
   end

   // Result register and skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_xfer) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_xfer;
            out_in       = result;
         end
      end else if (req_xfer) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         step_ff       <= '0;
         volume_ff     <= '0;
         knob_ff       <= '0;
         last_dir_ff   <= DIR_NONE;
         sample_ff     <= SampleMid;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         volume_ff     <= volume_in;
         knob_ff       <= knob_in;
         last_dir_ff   <= last_dir_in;
         sample_ff     <= sample_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_audio_level  = out_ff.audio_level;
   assign rsp_volume_level = out_ff.volume_level;
   assign rsp_note_active  = out_ff.note_active;

endmodule
